// ===== sv/trcc_pkg.sv =====
// Package with the shared types, widths and constants of the record chain checker.
package trcc_pkg;

	localparam int OFFSET_BITS   = 48;
	localparam int DATA_W        = 8;
	localparam int MAX_LEN_W     = 41;
	localparam int LEN_SHIFT_W   = 64;
	localparam int SIZE_W        = 48;
	localparam int VERDICT_W     = 2;

	localparam logic [OFFSET_BITS-1:0] OFF_MAX     = {OFFSET_BITS{1'b1}};
	localparam logic [OFFSET_BITS-1:0] FIRST_BEGIN = OFFSET_BITS'(4);
	localparam logic [OFFSET_BITS-1:0] MAGIC_LEN   = OFFSET_BITS'(4);
	localparam logic [OFFSET_BITS-1:0] ID_LEN      = OFFSET_BITS'(8);
	localparam logic [OFFSET_BITS-1:0] HDR_LEN     = OFFSET_BITS'(8'h11);
	localparam logic [LEN_SHIFT_W-1:0] MIN_LEN     = LEN_SHIFT_W'(15);
	localparam logic [MAX_LEN_W-1:0]   MAX_LEN_RST = MAX_LEN_W'(209715200);

	localparam logic [DATA_W-1:0] MAGIC_0 = 8'h46; // 'F'
	localparam logic [DATA_W-1:0] MAGIC_1 = 8'h53; // 'S'
	localparam logic [DATA_W-1:0] MAGIC_2 = 8'h32; // '2'
	localparam logic [DATA_W-1:0] MAGIC_3 = 8'h31; // '1'

	localparam logic [DATA_W-1:0] STATUS_SPACE = 8'h20; // ' '
	localparam logic [DATA_W-1:0] STATUS_P     = 8'h70; // 'p'
	localparam logic [DATA_W-1:0] STATUS_C     = 8'h63; // 'c'
	localparam logic [DATA_W-1:0] STATUS_U     = 8'h75; // 'u'

	typedef enum logic [VERDICT_W-1:0] {
		VERDICT_VALID    = 2'd0,
		VERDICT_REJECTED = 2'd1,
		VERDICT_STOPPED  = 2'd2
	} verdict_t;

	typedef struct packed {
		logic [DATA_W-1:0] data_byte;
		logic              start_of_file;
	} item_t;

	typedef struct packed {
		verdict_t          verdict;
		logic              record_accepted;
		logic [SIZE_W-1:0] computed_size;
	} result_t;

	function automatic logic [DATA_W-1:0] magic_byte(input logic [1:0] idx);
		logic [DATA_W-1:0] m;
		unique case (idx)
			2'd0: m = MAGIC_0;
			2'd1: m = MAGIC_1;
			2'd2: m = MAGIC_2;
			default: m = MAGIC_3;
		endcase
		return m;
	endfunction

	function automatic logic status_ok(input logic [DATA_W-1:0] s);
		return (s == STATUS_SPACE) || (s == STATUS_P) || (s == STATUS_C) || (s == STATUS_U);
	endfunction

endpackage

// ===== sv/trcc_if.sv =====
// Channel interfaces for the input byte stream and the result stream.
interface trcc_item_if;
	logic                        valid;
	logic                        ready;
	logic [trcc_pkg::DATA_W-1:0] data_byte;
	logic                        start_of_file;

	modport source (output valid, output data_byte, output start_of_file, input ready);
	modport sink   (input valid, input data_byte, input start_of_file, output ready);
endinterface

interface trcc_result_if;
	logic                           valid;
	logic                           ready;
	logic [trcc_pkg::VERDICT_W-1:0] verdict;
	logic                           record_accepted;
	logic [trcc_pkg::SIZE_W-1:0]    computed_size;

	modport source (output valid, output verdict, output record_accepted,
		output computed_size, input ready);
	modport sink   (input valid, input verdict, input record_accepted,
		input computed_size, output ready);
endinterface

// ===== sv/trcc_walk.sv =====
// Walk state of the record chain and the per-byte check logic.
module trcc_walk (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write_en,
	input  logic [trcc_pkg::MAX_LEN_W-1:0] cfg_write_data,
	input  logic                           step,
	input  trcc_pkg::item_t                item,
	output trcc_pkg::result_t              result
);
	import trcc_pkg::*;

	localparam int SUM_W = ((OFFSET_BITS > MAX_LEN_W + 1) ? OFFSET_BITS : MAX_LEN_W + 1) + 1;

	logic [MAX_LEN_W-1:0]   max_len_q;
	logic [OFFSET_BITS-1:0] pos_q;
	logic [OFFSET_BITS-1:0] rb_q;
	logic [LEN_SHIFT_W-1:0] len_q;
	verdict_t               verdict_q;
	logic                   first_q;

	logic [OFFSET_BITS-1:0] pos_base;
	logic [OFFSET_BITS-1:0] rb_base;
	logic [LEN_SHIFT_W-1:0] len_base;
	verdict_t               verdict_base;
	logic                   first_base;

	logic [OFFSET_BITS-1:0] pos_d;
	logic [OFFSET_BITS-1:0] rb_d;
	logic [LEN_SHIFT_W-1:0] len_d;
	verdict_t               verdict_d;
	logic                   first_d;
	logic                   accepted;

	logic [OFFSET_BITS-1:0] rel;
	logic [SUM_W-1:0]       next_begin;
	logic                   len_bad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RST;
		end else if (cfg_write_en) begin
			max_len_q <= cfg_write_data;
		end
	end

	// A new file restarts the walk before its first byte is checked.
	always_comb begin
		if (item.start_of_file) begin
			pos_base     = '0;
			rb_base      = FIRST_BEGIN;
			len_base     = '0;
			verdict_base = VERDICT_VALID;
			first_base   = 1'b1;
		end else begin
			pos_base     = pos_q;
			rb_base      = rb_q;
			len_base     = len_q;
			verdict_base = verdict_q;
			first_base   = first_q;
		end
	end

	assign rel        = pos_base - rb_base;
	assign next_begin = SUM_W'(rb_base) + SUM_W'(len_base[MAX_LEN_W-1:0]) + SUM_W'(ID_LEN);
	assign len_bad    = (len_base < MIN_LEN) || (len_base > LEN_SHIFT_W'(max_len_q));

	always_comb begin
		rb_d      = rb_base;
		len_d     = len_base;
		verdict_d = verdict_base;
		first_d   = first_base;
		accepted  = 1'b0;
		if (verdict_base == VERDICT_VALID && pos_base != OFF_MAX) begin
			if (pos_base < MAGIC_LEN) begin
				if (item.data_byte != magic_byte(pos_base[1:0])) begin
					verdict_d = VERDICT_REJECTED;
				end
			end else if (pos_base >= rb_base) begin
				if (rel >= ID_LEN && rel < ID_LEN + ID_LEN) begin
					len_d = {len_base[LEN_SHIFT_W-DATA_W-1:0], item.data_byte};
				end else if (rel == HDR_LEN - OFFSET_BITS'(1)) begin
					if (len_bad || !status_ok(item.data_byte)) begin
						verdict_d = first_base ? VERDICT_REJECTED : VERDICT_STOPPED;
					end else begin
						rb_d     = (next_begin > SUM_W'(OFF_MAX)) ? OFF_MAX
							: next_begin[OFFSET_BITS-1:0];
						first_d  = 1'b0;
						accepted = 1'b1;
					end
					len_d = '0;
				end
			end
		end
		pos_d = (pos_base != OFF_MAX) ? pos_base + OFFSET_BITS'(1) : pos_base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			rb_q      <= FIRST_BEGIN;
			len_q     <= '0;
			verdict_q <= VERDICT_VALID;
			first_q   <= 1'b1;
		end else if (step) begin
			pos_q     <= pos_d;
			rb_q      <= rb_d;
			len_q     <= len_d;
			verdict_q <= verdict_d;
			first_q   <= first_d;
		end
	end

	assign result.verdict         = verdict_d;
	assign result.record_accepted = accepted;
	assign result.computed_size   = SIZE_W'(rb_d);

	// A verdict, once given, holds until a new file begins.
	a_verdict_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !item.start_of_file && verdict_q != VERDICT_VALID)
		|=> verdict_q == $past(verdict_q))
		else $error("verdict changed without a new file");

	// Within one file the next record start only moves forward.
	a_begin_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !item.start_of_file) |=> rb_q >= $past(rb_q))
		else $error("record start moved backward");

	// An accepted record ends the first-record phase.
	a_accept_clears_first: assert property (@(posedge clk) disable iff (!arst_n)
		(step && result.record_accepted) |=> !first_q)
		else $error("first-record flag still set after an accepted record");

	// A record is only accepted while the walk is still valid.
	a_accept_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(step && result.record_accepted) |-> (verdict_base == VERDICT_VALID && rb_q >= FIRST_BEGIN))
		else $error("record accepted on a finished walk");

endmodule

// ===== sv/transaction_record_chain_checker.sv =====
// Top level of the transaction record chain checker: input and result registers around the walk.
// Each byte is captured in the input register, then its result in the output register.
// Throughput: one byte per cycle when results are taken, through a combinational check.
// Stalls on the result side back up through the input register without losing a transfer.
// Reset (arst_n low, asynchronous) empties both registers, restarts the walk and
// loads the maximum record length with 209715200.
module transaction_record_chain_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write_en,
	input  logic [trcc_pkg::MAX_LEN_W-1:0] cfg_write_data,
	trcc_item_if.sink                      items,
	trcc_result_if.source                  results
);
	import trcc_pkg::*;

	// Input register: holds one byte transfer until the walk logic consumes it.
	logic    in_valid_s1;
	item_t   item_s1;

	// Result register: holds one finished result until the sink takes it.
	logic    out_valid_s2;
	result_t result_s2;

	result_t walk_result;
	logic    advance;

	// The byte in the input register moves on when the result register is
	// empty or is being emptied in this same cycle. The walk state updates
	// with that same move, so every byte is checked exactly once.
	assign advance     = in_valid_s1 && (!out_valid_s2 || results.ready);
	assign items.ready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (items.valid && items.ready) begin
			in_valid_s1 <= 1'b1;
		end else if (advance) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			item_s1.data_byte     <= items.data_byte;
			item_s1.start_of_file <= items.start_of_file;
		end
	end

	// The walk holds the chain state and the length limit register; it
	// computes the result for the byte in the input register.
	trcc_walk u_walk (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.step           (advance),
		.item           (item_s1),
		.result         (walk_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (results.ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= walk_result;
		end
	end

	assign results.valid           = out_valid_s2;
	assign results.verdict         = result_s2.verdict;
	assign results.record_accepted = result_s2.record_accepted;
	assign results.computed_size   = result_s2.computed_size;

endmodule
